### sv/dcrc_pkg.sv
// shared types, constants and the crc-32c byte step for the dual crc hash
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dcrc_pkg;

  localparam logic [31:0] CrcPoly     = 32'h82F6_3B78;
  localparam logic [63:0] LaneBMask   = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [31:0] SeedAReset  = 32'hFFFF_FFFF;
  localparam logic [31:0] SeedBReset  = 32'h85EB_CA6B;
  localparam int unsigned NumBytes    = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned AddrW       = 3;

  typedef enum logic {
    REG_SEED_A = 1'b0,
    REG_SEED_B = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              accept;
    logic              reload;
    logic [CountW-1:0] count;
  } lane_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/dual_crc32c_stream_hash_core.sv
// dual crc-32c stream hash: two crc lanes side by side and a merging output stage
// depends on dcrc_pkg, dcrc_regs, dcrc_lane, dcrc_merge
//
// input channel in_valid_i / in_ready_o carries data_word_i (bytes, first in
// bits 7:0), byte_count_i (counts above eight act as eight) and last_i.
// lane a hashes the bytes as they are, lane b hashes them xored with 0xa5.
// one item is taken every cycle while in_ready_o is high; both lanes update
// in the same cycle through an eight-byte xor network that closes the loop on
// each lane register. on an item with last_i the result {lane b, lane a}
// appears on hash_value_o with out_valid_o in the cycle after acceptance, and
// both lanes reload from the seed registers.
// the output register holds one hash; while it waits on out_ready_i, items
// without last_i are still taken, a further last item waits until the held
// hash is taken (or is taken in the same cycle).
// seeds are written over the apb port (0x0 lane a, 0x4 lane b) and take
// effect at the next reload. reset sets the seeds to 0xffffffff and
// 0x85ebca6b, loads the lanes with them and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module dual_crc32c_stream_hash_core import dcrc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [63:0]       data_word_i,
  input  wire logic [CountW-1:0] byte_count_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [63:0]       hash_value_o
);

  logic [31:0] seed_a, seed_b;
  logic [31:0] crc_a, crc_b;
  lane_ctl_t   ctl;
  logic [63:0] data_b;

  assign ctl.accept = in_valid_i && in_ready_o;
  assign ctl.reload = last_i;
  assign ctl.count  = byte_count_i;
  assign data_b     = data_word_i ^ LaneBMask;

  dcrc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .seed_a_o (seed_a),
    .seed_b_o (seed_b)
  );

  dcrc_lane u_lane_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .reset_seed_i (SeedAReset),
    .seed_i       (seed_a),
    .data_i       (data_word_i),
    .crc_next_o   (crc_a)
  );

  dcrc_lane u_lane_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .reset_seed_i (SeedBReset),
    .seed_i       (seed_b),
    .data_i       (data_b),
    .crc_next_o   (crc_b)
  );

  dcrc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_i       (last_i),
    .in_ready_o   (in_ready_o),
    .crc_a_i      (crc_a),
    .crc_b_i      (crc_b),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule

`default_nettype wire

### sv/dcrc_regs.sv
// apb seed registers for both crc lanes
// depends on dcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcrc_regs import dcrc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [31:0]      seed_a_o,
  output logic      [31:0]      seed_b_o
);

  logic [31:0] seed_a_q, seed_a_d;
  logic [31:0] seed_b_q, seed_b_d;
  reg_idx_e    idx;
  logic        wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    seed_a_d = seed_a_q;
    seed_b_d = seed_b_q;
    if (wr_en) begin
      case (idx)
        REG_SEED_A: seed_a_d = pwdata;
        REG_SEED_B: seed_b_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEED_A: prdata = seed_a_q;
      REG_SEED_B: prdata = seed_b_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= SeedAReset;
      seed_b_q <= SeedBReset;
    end else begin
      seed_a_q <= seed_a_d;
      seed_b_q <= seed_b_d;
    end
  end

  assign seed_a_o = seed_a_q;
  assign seed_b_o = seed_b_q;

endmodule

`default_nettype wire

### sv/dcrc_lane.sv
// one crc-32c lane: running crc register and eight-byte update network
// depends on dcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcrc_lane import dcrc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lane_ctl_t ctl_i,
  input  wire logic [31:0] reset_seed_i,
  input  wire logic [31:0] seed_i,
  input  wire logic [63:0] data_i,
  output logic      [31:0] crc_next_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] chain [NumBytes+1];

  always_comb begin
    chain[0] = crc_q;
    for (int k = 0; k < NumBytes; k++) begin
      chain[k+1] = (CountW'(k) < ctl_i.count) ? crc_byte(chain[k], data_i[8*k +: 8])
                                             : chain[k];
    end
  end

  assign crc_next_o = chain[NumBytes];

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.accept) begin
      crc_d = ctl_i.reload ? seed_i : crc_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= reset_seed_i;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

### sv/dcrc_merge.sv
// joins both lane results into the hash word and holds it in the output register
// depends on dcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcrc_merge import dcrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        last_i,
  output logic             in_ready_o,
  input  wire logic [31:0] crc_a_i,
  input  wire logic [31:0] crc_b_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [63:0] hash_value_o
);

  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;
  logic        emit;

  // items without last never need the output register
  assign in_ready_o = !last_i || !out_valid_q || out_ready_i;
  assign emit       = in_valid_i && in_ready_o && last_i;

  always_comb begin
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      hash_d      = {crc_b_i, crc_a_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("hash not presented after last item");

  a_emit_loads_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> hash_q == $past({crc_b_i, crc_a_i}))
    else $error("hash register missed lane results");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && !emit) |=> (out_valid_q && $stable(hash_q)))
    else $error("pending hash lost or changed");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with free output register");

endmodule

`default_nettype wire

### verif/dual_crc32c_stream_hash_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for dual_crc32c_stream_hash_core: directed and random items,
// seed writes over apb, a local dual-lane crc-32c predictor and an in-order hash checker
// depends on dcrc_pkg and the core rtl
module dual_crc32c_stream_hash_core_test import dcrc_pkg::*;;

  localparam logic [31:0] CastagnoliPoly = 32'h82F6_3B78;
  localparam logic [7:0]  MaskByte       = 8'hA5;
  localparam int unsigned DrainCycles    = 4;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [AddrW-1:0]  paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [63:0]       data_word_i  = '0;
  logic [CountW-1:0] byte_count_i = '0;
  logic              last_i       = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [63:0]       hash_value_o;

  logic [31:0] seed_a_shadow = 32'hFFFF_FFFF;
  logic [31:0] seed_b_shadow = 32'h85EB_CA6B;
  logic [31:0] lane_a_crc    = 32'hFFFF_FFFF;
  logic [31:0] lane_b_crc    = 32'h85EB_CA6B;
  logic [63:0] pending_hashes[$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 14;
  int unsigned sink_idle_pct  = 14;
  logic        sink_hold      = 1'b0;

  dual_crc32c_stream_hash_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] crc32c_feed_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[31:1]} ^ (fb ? CastagnoliPoly : 32'd0);
    end
    return r;
  endfunction

  function automatic void absorb_item(input logic [63:0] word, input logic [3:0] cnt,
                                      input logic fin);
    int unsigned nbytes;
    nbytes = (cnt > 4'd8) ? 8 : cnt;
    for (int unsigned i = 0; i < nbytes; i++) begin
      lane_a_crc = crc32c_feed_byte(lane_a_crc, word[8*i +: 8]);
      lane_b_crc = crc32c_feed_byte(lane_b_crc, word[8*i +: 8] ^ MaskByte);
    end
    if (fin) begin
      pending_hashes.push_back({lane_b_crc, lane_a_crc});
      lane_a_crc = seed_a_shadow;
      lane_b_crc = seed_b_shadow;
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
    if (mismatch_count < 10) begin
      $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
    end
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      absorb_item(data_word_i, byte_count_i, last_i);
    end
  end

  always @(posedge clk_i) begin : check_hashes
    logic [63:0] want_hash;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hashes.size() == 0) begin
        note_mismatch("hash with none pending", '0, hash_value_o);
      end else begin
        want_hash = pending_hashes.pop_front();
        if (hash_value_o !== want_hash) begin
          note_mismatch("hash_value", want_hash, hash_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_item(input logic [63:0] word, input logic [3:0] cnt, input logic fin);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= word;
    byte_count_i <= cnt;
    last_i       <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SEED_A: seed_a_shadow = value;
      default:    seed_b_shadow = value;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== value) begin
      note_mismatch("seed readback", {32'd0, value}, {32'd0, prdata});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_items();
    // zero count with last emits the seeds untouched
    send_item(64'h0, 4'd0, 1'b1);
    send_item('1, 4'd8, 1'b1);
    send_item(64'h0, 4'd8, 1'b0);
    send_item(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1);
    for (int c = 0; c < 16; c++) begin
      send_item({$urandom(), $urandom()}, 4'(c), (c % 4 == 3));
    end
    send_item('1, 4'd0, 1'b1);
    settle();
  endtask

  task automatic test_seed_extremes();
    logic [31:0] sa;
    logic [31:0] sb;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin
          sa = 32'h0;
          sb = 32'h0;
        end
        1: begin
          sa = 32'hFFFF_FFFF;
          sb = 32'hFFFF_FFFF;
        end
        2: begin
          sa = 32'h0;
          sb = 32'hFFFF_FFFF;
        end
        default: begin
          sa = $urandom();
          sb = $urandom();
        end
      endcase
      write_seed(REG_SEED_A, sa);
      write_seed(REG_SEED_B, sb);
      send_item(64'h0, 4'd0, 1'b1);
      repeat (3) send_item({$urandom(), $urandom()}, 4'($urandom_range(15)),
                           1'($urandom_range(1)));
      send_item({$urandom(), $urandom()}, 4'd8, 1'b1);
      settle();
    end
  endtask

  task automatic test_seed_midstream();
    send_item({$urandom(), $urandom()}, 4'd8, 1'b0);
    send_item({$urandom(), $urandom()}, 4'd5, 1'b0);
    settle();
    write_seed(REG_SEED_A, $urandom());
    write_seed(REG_SEED_B, $urandom());
    // stream in flight keeps its lanes, new seeds apply after this last item
    send_item({$urandom(), $urandom()}, 4'd8, 1'b1);
    send_item({$urandom(), $urandom()}, 4'd3, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    logic        noisy;
    logic [3:0]  cnt;
    logic        fin;
    for (int phase = 0; phase < 4; phase++) begin
      write_seed(REG_SEED_A, (phase == 1) ? 32'h0 : 32'($urandom()));
      write_seed(REG_SEED_B, (phase == 1) ? 32'hFFFF_FFFF : 32'($urandom()));
      src_idle_pct  = (phase == 2) ? 0 : 14;
      sink_idle_pct <= (phase == 2) ? 0 : 14;
      sent = 0;
      while (sent < 260) begin
        noisy = ($urandom_range(9) == 0);
        len   = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          cnt = ($urandom_range(9) < 7) ? 4'd8 : 4'($urandom_range(15));
          fin = noisy ? 1'($urandom_range(1)) : (k == len - 1);
          send_item({$urandom(), $urandom()}, cnt, fin);
        end
        sent += len;
      end
      settle();
    end
    src_idle_pct  = 14;
    sink_idle_pct <= 14;
  endtask

  task automatic test_output_stall();
    fork
      begin
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    for (int k = 0; k < 40; k++) begin
      send_item({$urandom(), $urandom()}, 4'($urandom_range(1, 8)), 1'(k % 2));
    end
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_items();
    test_seed_extremes();
    test_seed_midstream();
    test_random_traffic();
    test_output_stall();
    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_hashes.size() == 0) begin
      $display("dual_crc32c_stream_hash_core verification clean");
    end else begin
      $display("dual_crc32c_stream_hash_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dual_crc32c_stream_hash_core verification failed");
    $finish;
  end

endmodule

### dual_crc32c_stream_hash_core.f
sv/dcrc_pkg.sv
sv/dcrc_regs.sv
sv/dcrc_lane.sv
sv/dcrc_merge.sv
sv/dual_crc32c_stream_hash_core.sv
verif/dual_crc32c_stream_hash_core_test.sv
